@@ hdl/cmc_pkg.sv @@
package cmc_pkg;

	localparam int MAX_VERTICES = 1024;
	localparam int AW = $clog2(MAX_VERTICES);
	localparam int CW = AW + 1;

	localparam int MARK_W = 35;
	localparam int LIM_W = 34;
	localparam int TOT_W = 32;

	typedef enum logic [2:0] {
		REQ_CLEAR_MARKS  = 3'd0,
		REQ_VISIT        = 3'd1,
		REQ_LOAD         = 3'd2,
		REQ_READ         = 3'd3,
		REQ_CLEAR_TOTALS = 3'd4
	} req_t;

	typedef enum logic [1:0] {
		KIND_CONTRIB = 2'd0,
		KIND_TOTAL   = 2'd1,
		KIND_ACK     = 2'd2
	} kind_t;

	localparam logic [1:0] MODE_PLAIN  = 2'd0;
	localparam logic [1:0] MODE_COUNT  = 2'd1;
	localparam logic [1:0] MODE_WEIGHT = 2'd2;

	localparam logic CFG_MODE   = 1'b0;
	localparam logic CFG_VCOUNT = 1'b1;

	typedef struct packed {
		req_t        req;
		logic [9:0]  vertex;
		logic [9:0]  neighbor;
		logic [15:0] weight;
		logic        has_neighbor;
		logic        last;
		logic [9:0]  cth;
		logic [23:0] wth;
	} item_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [10:0] vcount;
	} cfg_t;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_RD_NB,
		S_TOUCH,
		S_RD_V,
		S_FIN,
		S_CLR_M,
		S_CLR_T,
		S_ACK
	} state_t;

endpackage

@@ hdl/coverage_marginal_contribution_core.sv @@
// visit entry: read neighbor mark and limit, then write its mark if touched; no result unless last
// last visit entry: then read vertex mark and total, and register contribution and total
// read: read the vertex total and register it; load: write the limit, then register an ack
// clears sweep entries below min(vertex_count, 1024), then ack; one transaction at a time
// reset: asynchronous active low; then a sweep zeroes all 1024 marks and totals,
// input is stalled until it ends; configuration writes are taken at any time
module coverage_marginal_contribution_core (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  req_type,
	input  logic [9:0]  vertex,
	input  logic [9:0]  neighbor,
	input  logic [15:0] weight,
	input  logic        has_neighbor,
	input  logic        last,
	input  logic [9:0]  count_threshold,
	input  logic [23:0] weight_threshold,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  result_kind,
	output logic [9:0]  out_vertex,
	output logic [10:0] contribution,
	output logic [31:0] total,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [10:0] cfg_data
);

	cmc_pkg::cfg_t  cfg_q;
	cmc_pkg::item_t in_item, q_item;
	logic           q_valid, pop, init_busy;

	// configuration is always writable
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode <= cmc_pkg::MODE_PLAIN;
			cfg_q.vcount <= 11'd1024;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				cmc_pkg::CFG_MODE: cfg_q.mode <= cfg_data[1:0];
				cmc_pkg::CFG_VCOUNT: cfg_q.vcount <= cfg_data;
				default: ;
			endcase
		end
	end

	// pack the input transaction
	always_comb begin
		in_item.req = cmc_pkg::req_t'(req_type);
		in_item.vertex = vertex;
		in_item.neighbor = neighbor;
		in_item.weight = weight;
		in_item.has_neighbor = has_neighbor;
		in_item.last = last;
		in_item.cth = count_threshold;
		in_item.wth = weight_threshold;
	end

	// front: accept, drop unknown requests, two-entry queue
	cmc_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_item(in_item), .hold(init_busy), .q_valid(q_valid), .q_item(q_item), .pop(pop)
	);

	// back: table sequencer and result register
	cmc_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .q_valid(q_valid), .q_item(q_item),
		.pop(pop), .init_busy(init_busy), .out_valid(out_valid), .out_stall(out_stall),
		.result_kind(result_kind), .out_vertex(out_vertex), .contribution(contribution),
		.total(total)
	);

endmodule

@@ hdl/cmc_ram.sv @@
module cmc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ hdl/cmc_front.sv @@
module cmc_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  cmc_pkg::item_t in_item,
	input  logic           hold,
	output logic           q_valid,
	output cmc_pkg::item_t q_item,
	input  logic           pop
);

	cmc_pkg::item_t slot_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;
	logic           accept;
	logic           push;
	logic           known;

	// requests five to seven are dropped here
	assign known = (in_item.req == cmc_pkg::REQ_CLEAR_MARKS) ||
		(in_item.req == cmc_pkg::REQ_VISIT) || (in_item.req == cmc_pkg::REQ_LOAD) ||
		(in_item.req == cmc_pkg::REQ_READ) || (in_item.req == cmc_pkg::REQ_CLEAR_TOTALS);

	assign in_stall = (cnt_q == 2'd2) || hold;
	assign accept = in_valid && !in_stall;
	assign push = accept && known;
	assign q_valid = (cnt_q != 2'd0);
	assign q_item = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop && q_valid) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop && q_valid);
		end
	end

endmodule

@@ hdl/cmc_back.sv @@
module cmc_back (
	input  logic           clk,
	input  logic           arst_n,
	input  cmc_pkg::cfg_t  cfg,
	input  logic           q_valid,
	input  cmc_pkg::item_t q_item,
	output logic           pop,
	output logic           init_busy,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [1:0]     result_kind,
	output logic [9:0]     out_vertex,
	output logic [10:0]    contribution,
	output logic [31:0]    total
);

	cmc_pkg::state_t state_q, state_d;
	cmc_pkg::item_t  item_q, item_d;
	logic [10:0]     pend_q, pend_d;
	logic [cmc_pkg::CW-1:0] cnt_q, cnt_d, n_use;

	logic                      m_we, l_we, t_we;
	logic [cmc_pkg::AW-1:0]    m_waddr, m_raddr, l_waddr, l_raddr, t_waddr, t_raddr;
	logic [cmc_pkg::MARK_W-1:0] m_wdata, m_rd;
	logic [cmc_pkg::LIM_W-1:0]  l_wdata, l_rd;
	logic [cmc_pkg::TOT_W-1:0]  t_wdata, t_rd;

	logic        cov, hit, do_touch, v_ok, nb_ok, out_free, load_out;
	logic [9:0]  et, el, et_inc, t_et;
	logic [23:0] wt, wl, wt_new, t_wt;
	logic [24:0] wsum;
	logic [10:0] p_self;
	logic [32:0] tsum;
	logic [31:0] t_new;
	logic [1:0]  o_kind;
	logic [10:0] o_contrib;
	logic [31:0] o_total;
	logic        out_valid_q;

	cmc_ram #(.WIDTH(cmc_pkg::MARK_W), .DEPTH(cmc_pkg::MAX_VERTICES)) u_marks (
		.clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata), .raddr(m_raddr), .rdata(m_rd)
	);
	cmc_ram #(.WIDTH(cmc_pkg::LIM_W), .DEPTH(cmc_pkg::MAX_VERTICES)) u_limits (
		.clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata), .raddr(l_raddr), .rdata(l_rd)
	);
	cmc_ram #(.WIDTH(cmc_pkg::TOT_W), .DEPTH(cmc_pkg::MAX_VERTICES)) u_totals (
		.clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata), .raddr(t_raddr), .rdata(t_rd)
	);

	assign cov = m_rd[34];
	assign et = m_rd[33:24];
	assign wt = m_rd[23:0];
	assign el = l_rd[33:24];
	assign wl = l_rd[23:0];
	assign v_ok = (32'(item_q.vertex) < cmc_pkg::MAX_VERTICES);
	assign nb_ok = (32'(item_q.neighbor) < cmc_pkg::MAX_VERTICES);
	assign n_use = (32'(cfg.vcount) > cmc_pkg::MAX_VERTICES) ?
		cmc_pkg::CW'(cmc_pkg::MAX_VERTICES) : cmc_pkg::CW'(cfg.vcount);

	assign m_raddr = (state_q == cmc_pkg::S_RD_NB) ?
		cmc_pkg::AW'(item_q.neighbor) : cmc_pkg::AW'(item_q.vertex);
	assign l_raddr = cmc_pkg::AW'(item_q.neighbor);
	assign t_raddr = cmc_pkg::AW'(item_q.vertex);

	// coverage rule on the neighbor entry
	always_comb begin
		et_inc = (et == 10'h3ff) ? et : et + 10'd1;
		wsum = {1'b0, wt} + 25'(item_q.weight);
		wt_new = wsum[24] ? 24'hffffff : wsum[23:0];
		t_et = et;
		t_wt = wt;
		case (cfg.mode)
			cmc_pkg::MODE_COUNT: begin
				hit = (et_inc >= el);
				t_et = et_inc;
			end
			cmc_pkg::MODE_WEIGHT: begin
				hit = (wt_new >= wl);
				t_wt = wt_new;
			end
			default: hit = 1'b1;
		endcase
		do_touch = item_q.has_neighbor && nb_ok && !cov;
		p_self = (v_ok && !cov && pend_q != 11'h7ff) ? pend_q + 11'd1 : pend_q;
		tsum = {1'b0, t_rd} + 33'(p_self);
		t_new = tsum[32] ? 32'hffffffff : tsum[31:0];
	end

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		item_d = item_q;
		pend_d = pend_q;
		cnt_d = cnt_q;
		pop = 1'b0;
		m_we = 1'b0;
		m_waddr = cmc_pkg::AW'(item_q.neighbor);
		m_wdata = {1'b1, t_et, t_wt};
		l_we = 1'b0;
		l_waddr = cmc_pkg::AW'(q_item.vertex);
		l_wdata = {q_item.cth, q_item.wth};
		t_we = 1'b0;
		t_waddr = cmc_pkg::AW'(item_q.vertex);
		t_wdata = t_new;
		load_out = 1'b0;
		o_kind = cmc_pkg::KIND_ACK;
		o_contrib = 11'd0;
		o_total = 32'd0;
		case (state_q)
			cmc_pkg::S_INIT: begin
				m_we = 1'b1;
				t_we = 1'b1;
				m_waddr = cnt_q[cmc_pkg::AW-1:0];
				t_waddr = cnt_q[cmc_pkg::AW-1:0];
				m_wdata = '0;
				t_wdata = '0;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == cmc_pkg::CW'(cmc_pkg::MAX_VERTICES - 1)) begin
					state_d = cmc_pkg::S_IDLE;
				end
			end
			cmc_pkg::S_IDLE: begin
				if (q_valid) begin
					pop = 1'b1;
					item_d = q_item;
					cnt_d = '0;
					case (q_item.req)
						cmc_pkg::REQ_VISIT: state_d = cmc_pkg::S_RD_NB;
						cmc_pkg::REQ_READ: state_d = cmc_pkg::S_RD_V;
						cmc_pkg::REQ_LOAD: begin
							l_we = (32'(q_item.vertex) < cmc_pkg::MAX_VERTICES);
							state_d = cmc_pkg::S_ACK;
						end
						cmc_pkg::REQ_CLEAR_MARKS: begin
							pend_d = '0;
							state_d = cmc_pkg::S_CLR_M;
						end
						default: state_d = cmc_pkg::S_CLR_T;
					endcase
				end
			end
			cmc_pkg::S_RD_NB: state_d = cmc_pkg::S_TOUCH;
			cmc_pkg::S_TOUCH: begin
				if (do_touch) begin
					m_we = 1'b1;
					m_wdata = {hit, t_et, t_wt};
					if (hit && pend_q != 11'h7ff) begin
						pend_d = pend_q + 11'd1;
					end
				end
				state_d = item_q.last ? cmc_pkg::S_RD_V : cmc_pkg::S_IDLE;
			end
			cmc_pkg::S_RD_V: state_d = cmc_pkg::S_FIN;
			cmc_pkg::S_FIN: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d = cmc_pkg::S_IDLE;
					if (item_q.req == cmc_pkg::REQ_READ) begin
						o_kind = cmc_pkg::KIND_TOTAL;
						o_total = v_ok ? t_rd : 32'd0;
					end else begin
						o_kind = cmc_pkg::KIND_CONTRIB;
						o_contrib = p_self;
						o_total = v_ok ? t_new : 32'd0;
						m_we = v_ok && !cov;
						m_waddr = cmc_pkg::AW'(item_q.vertex);
						m_wdata = {1'b1, et, wt};
						t_we = v_ok;
						pend_d = '0;
					end
				end
			end
			cmc_pkg::S_CLR_M, cmc_pkg::S_CLR_T: begin
				if (cnt_q < n_use) begin
					m_we = (state_q == cmc_pkg::S_CLR_M);
					t_we = (state_q == cmc_pkg::S_CLR_T);
					m_waddr = cnt_q[cmc_pkg::AW-1:0];
					t_waddr = cnt_q[cmc_pkg::AW-1:0];
					m_wdata = '0;
					t_wdata = '0;
					cnt_d = cnt_q + 1'b1;
				end else begin
					state_d = cmc_pkg::S_ACK;
				end
			end
			cmc_pkg::S_ACK: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d = cmc_pkg::S_IDLE;
				end
			end
			default: state_d = cmc_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cmc_pkg::S_INIT;
			pend_q <= '0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q <= pend_d;
			cnt_q <= cnt_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		item_q <= item_d;
		if (load_out) begin
			result_kind <= o_kind;
			out_vertex <= item_q.vertex;
			contribution <= o_contrib;
			total <= o_total;
		end
	end

	assign out_valid = out_valid_q;
	assign init_busy = (state_q == cmc_pkg::S_INIT);

	a_no_pop_in_init: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cmc_pkg::S_INIT) |-> !pop)
		else $error("queue popped during reset sweep");
	a_clear_marks_only: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cmc_pkg::S_CLR_M) |-> !t_we)
		else $error("totals written while clearing marks");
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == cmc_pkg::S_FIN ||
		$past(state_q) == cmc_pkg::S_ACK))
		else $error("result raised from unexpected state");
	a_pend_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cmc_pkg::S_FIN && load_out && item_q.req == cmc_pkg::REQ_VISIT)
		|=> (pend_q == 11'd0))
		else $error("pending count kept after join");

endmodule
